[hdl/lzd_pkg.sv]
`default_nettype none
package lzd_pkg;

  localparam int WINDOW_SIZE = 4096;
  localparam int AW          = $clog2(WINDOW_SIZE);
  localparam int SIZE_W      = 24;
  localparam int LEN_W       = 5;
  localparam int MIN_MATCH   = 3;
  localparam int MAX_MATCH   = 18;
  localparam int CMD_DEPTH   = 4;
  localparam int CMD_PW      = $clog2(CMD_DEPTH);

  localparam logic [7:0] TAG_RESET = 8'd16;

  // command kinds
  localparam logic [1:0] K_LIT  = 2'd0;
  localparam logic [1:0] K_COPY = 2'd1;
  localparam logic [1:0] K_ERR  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_TAG  = 2'd1;
  localparam logic [1:0] ST_DIST = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data;
    logic [LEN_W-1:0] len;
    logic [AW-1:0]    distance;
    logic [AW-1:0]    base;
    logic             last;
    logic [1:0]       status;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } res_t;

endpackage
`default_nettype wire

[hdl/lz77_stream_decompressor_core.sv]
// LZSS stream decompressor, 4096-byte history, match lengths 3 to 18.
// Input queue side: present in_byte/start_req with push; the item is taken on
// an edge where push is high and full is low. start_req marks a tag byte and
// restarts parsing at any time. Result queue side: while empty is low the
// oldest result sits on out_byte/last/status; pop takes it.
// cfg_we/cfg_data write the expected header tag (16 after reset); write only
// while the block is idle.
// The parser classifies one input item per cycle while full is low into literal,
// copy or error commands held in a four-entry queue. The copy engine emits one
// byte per cycle while the result queue has room. A result passes through the
// command queue, the issue stage, the write/emit stage and the result queue.
// Reset clears parse state and queues and sets the tag back to 16; the history is not cleared.
// When the receiver stalls, the two-entry result queue fills, the copy engine
// holds, then the command queue fills and full rises.
`default_nettype none
module lz77_stream_decompressor_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       start_req,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte,
  output logic            last,
  output logic [1:0]      status,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_data
);

  lzd_pkg::cmd_t cmd_in, cmd_head;
  lzd_pkg::res_t res;
  logic          cmd_push, cmd_full, cmd_empty, cmd_pop, accept;

  assign full   = cmd_full;
  assign accept = push && !cmd_full;

  lzd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .in_byte   (in_byte),
    .start_req (start_req),
    .cmd       (cmd_in),
    .cmd_push  (cmd_push)
  );

  lzd_cmd_fifo u_cmd_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .rdata (cmd_head),
    .empty (cmd_empty)
  );

  lzd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd_head  (cmd_head),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .res       (res)
  );

  assign out_byte = res.data;
  assign last     = res.last;
  assign status   = res.status;

endmodule
`default_nettype wire

[hdl/lzd_front.sv]
`default_nettype none
module lzd_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [7:0]    cfg_data,
  input  wire logic          accept,
  input  wire logic [7:0]    in_byte,
  input  wire logic          start_req,
  output lzd_pkg::cmd_t      cmd,
  output logic               cmd_push
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_SIZE0 = 3'd1;
  localparam logic [2:0] PH_SIZE1 = 3'd2;
  localparam logic [2:0] PH_SIZE2 = 3'd3;
  localparam logic [2:0] PH_FLAG  = 3'd4;
  localparam logic [2:0] PH_ITEM  = 3'd5;
  localparam logic [2:0] PH_TOK2  = 3'd6;

  localparam int SW = lzd_pkg::SIZE_W;
  localparam int LW = lzd_pkg::LEN_W;
  localparam int AW = lzd_pkg::AW;

  logic [7:0]    expected_tag;
  logic [2:0]    phase, phase_next;
  logic [SW-1:0] declared, declared_next;
  logic [SW-1:0] pc, pc_next;          // bytes promised to the back end so far
  logic [7:0]    flag_bits, flag_bits_next;
  logic [2:0]    flag_index, flag_index_next;
  logic [7:0]    token_high, token_high_next;

  logic [SW-1:0] pc_inc, remaining, pc_copy;
  logic [LW-1:0] tok_len, copy_len;
  logic [AW:0]   tok_dist;
  logic          dist_bad, tok_ends, cur_flag, lit_last;
  logic [2:0]    adv_phase;

  assign pc_inc    = pc + SW'(1);
  assign remaining = declared - pc;
  assign tok_len   = LW'(token_high[7:4]) + LW'(lzd_pkg::MIN_MATCH);
  assign tok_dist  = {1'b0, token_high[3:0], in_byte} + (AW + 1)'(1);
  assign dist_bad  = SW'(tok_dist) > pc;
  assign tok_ends  = SW'(tok_len) >= remaining;
  assign copy_len  = tok_ends ? remaining[LW-1:0] : tok_len;
  assign pc_copy   = pc + SW'(copy_len);
  assign cur_flag  = flag_bits[3'd7 - flag_index];
  assign lit_last  = (pc_inc == declared);
  assign adv_phase = (flag_index == 3'd7) ? PH_FLAG : PH_ITEM;

  always_comb begin
    phase_next      = phase;
    declared_next   = declared;
    pc_next         = pc;
    flag_bits_next  = flag_bits;
    flag_index_next = flag_index;
    token_high_next = token_high;
    cmd_push        = 1'b0;
    cmd             = '0;
    cmd.base        = pc[AW-1:0];
    cmd.status      = lzd_pkg::ST_OK;
    if (accept) begin
      if (start_req) begin
        pc_next         = '0;
        declared_next   = '0;
        flag_bits_next  = '0;
        flag_index_next = '0;
        token_high_next = '0;
        if (in_byte != expected_tag) begin
          phase_next = PH_IDLE;
          cmd_push   = 1'b1;
          cmd.kind   = lzd_pkg::K_ERR;
          cmd.len    = LW'(1);
          cmd.last   = 1'b1;
          cmd.status = lzd_pkg::ST_TAG;
        end else begin
          phase_next = PH_SIZE0;
        end
      end else begin
        unique case (phase)
          PH_IDLE: ;
          PH_SIZE0: begin
            declared_next = SW'(in_byte);
            phase_next    = PH_SIZE1;
          end
          PH_SIZE1: begin
            declared_next = {declared[SW-1:16], in_byte, declared[7:0]};
            phase_next    = PH_SIZE2;
          end
          PH_SIZE2: begin
            declared_next = {in_byte, declared[15:0]};
            phase_next    = ({in_byte, declared[15:0]} == '0) ? PH_IDLE : PH_FLAG;
          end
          PH_FLAG: begin
            flag_bits_next  = in_byte;
            flag_index_next = '0;
            phase_next      = PH_ITEM;
          end
          PH_ITEM: begin
            if (cur_flag) begin
              token_high_next = in_byte;
              phase_next      = PH_TOK2;
            end else begin
              cmd_push        = 1'b1;
              cmd.kind        = lzd_pkg::K_LIT;
              cmd.data        = in_byte;
              cmd.len         = LW'(1);
              cmd.last        = lit_last;
              pc_next         = pc_inc;
              phase_next      = lit_last ? PH_IDLE : adv_phase;
              flag_index_next = flag_index + 3'd1;
            end
          end
          PH_TOK2: begin
            cmd_push = 1'b1;
            if (dist_bad) begin
              cmd.kind   = lzd_pkg::K_ERR;
              cmd.len    = LW'(1);
              cmd.last   = 1'b1;
              cmd.status = lzd_pkg::ST_DIST;
              phase_next = PH_IDLE;
            end else begin
              cmd.kind        = lzd_pkg::K_COPY;
              cmd.len         = copy_len;
              cmd.distance    = tok_dist[AW-1:0];   // 4096 folds to 0, same ring slot
              cmd.last        = tok_ends;
              pc_next         = pc_copy;
              phase_next      = tok_ends ? PH_IDLE : adv_phase;
              flag_index_next = flag_index + 3'd1;
            end
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_tag <= lzd_pkg::TAG_RESET;
      phase        <= PH_IDLE;
      declared     <= '0;
      pc           <= '0;
      flag_bits    <= '0;
      flag_index   <= '0;
      token_high   <= '0;
    end else begin
      if (cfg_we) begin
        expected_tag <= cfg_data;
      end
      phase      <= phase_next;
      declared   <= declared_next;
      pc         <= pc_next;
      flag_bits  <= flag_bits_next;
      flag_index <= flag_index_next;
      token_high <= token_high_next;
    end
  end

  a_copy_len: assert property (@(posedge clk) disable iff (rst)
    (cmd_push && cmd.kind == lzd_pkg::K_COPY) |->
      (cmd.len >= LW'(1) && cmd.len <= LW'(lzd_pkg::MAX_MATCH)))
    else $error("copy length out of range");

  a_pc_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_FLAG || phase == PH_ITEM || phase == PH_TOK2) |-> (pc < declared))
    else $error("output count reached declared size while stream active");

  a_err_cmd_last: assert property (@(posedge clk) disable iff (rst)
    (cmd_push && cmd.kind == lzd_pkg::K_ERR) |-> cmd.last)
    else $error("error command without last mark");

endmodule
`default_nettype wire

[hdl/lzd_cmd_fifo.sv]
`default_nettype none
module lzd_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire lzd_pkg::cmd_t wdata,
  output logic               full,
  input  wire logic          pop,
  output lzd_pkg::cmd_t      rdata,
  output logic               empty
);

  localparam int PW = lzd_pkg::CMD_PW;

  lzd_pkg::cmd_t entries [lzd_pkg::CMD_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;
  logic          do_push, do_pop;

  assign full    = (count == (PW + 1)'(lzd_pkg::CMD_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + (PW + 1)'(1);
        2'b01:   count <= count - (PW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[hdl/lzd_back.sv]
`default_nettype none
module lzd_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_empty,
  input  wire lzd_pkg::cmd_t cmd_head,
  output logic               cmd_pop,
  input  wire logic          pop,
  output logic               empty,
  output lzd_pkg::res_t      res
);

  localparam int AW = lzd_pkg::AW;
  localparam int LW = lzd_pkg::LEN_W;

  // history ring
  logic [7:0] history [lzd_pkg::WINDOW_SIZE];
  logic [7:0] mem_q;

  // issue stage
  logic          a_valid;
  lzd_pkg::cmd_t a_cmd;
  logic [LW-1:0] a_idx;
  logic          a_fire, a_done, a_last_elem;
  logic [AW-1:0] ra, wa;

  // write/emit stage
  logic          b_valid, b_copy, b_last, fwd;
  logic [7:0]    b_lit, fwd_data, b_value;
  logic [AW-1:0] b_wa;
  logic [1:0]    b_status;
  logic          b_fire, mem_we;

  // result queue, two entries
  lzd_pkg::res_t out_q [2];
  logic          o_wr, o_rd;
  logic [1:0]    o_count;
  logic          o_push, o_pop;

  assign a_last_elem = (a_idx == a_cmd.len - LW'(1));
  assign a_fire      = a_valid && (!b_valid || b_fire);
  assign a_done      = a_fire && a_last_elem;
  assign cmd_pop     = !cmd_empty && (!a_valid || a_done);
  assign wa          = a_cmd.base + AW'(a_idx);
  assign ra          = wa - a_cmd.distance;

  assign b_value = (b_status != lzd_pkg::ST_OK) ? 8'd0 :
                   (b_copy ? (fwd ? fwd_data : mem_q) : b_lit);
  assign b_fire  = b_valid && (o_count != 2'd2);
  assign mem_we  = b_fire && (b_status == lzd_pkg::ST_OK);

  always_ff @(posedge clk) begin
    if (a_fire) begin
      mem_q <= history[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      history[b_wa] <= b_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      a_cmd <= cmd_head;
    end
    if (a_fire) begin
      b_copy   <= (a_cmd.kind == lzd_pkg::K_COPY);
      b_lit    <= a_cmd.data;
      b_wa     <= wa;
      b_last   <= a_cmd.last && a_last_elem;
      b_status <= a_cmd.status;
      // byte written this cycle is not yet visible to the read port
      fwd      <= mem_we && (ra == b_wa);
      fwd_data <= b_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      a_idx   <= '0;
      b_valid <= 1'b0;
    end else begin
      if (cmd_pop) begin
        a_valid <= 1'b1;
        a_idx   <= '0;
      end else if (a_done) begin
        a_valid <= 1'b0;
      end else if (a_fire) begin
        a_idx <= a_idx + LW'(1);
      end
      if (a_fire) begin
        b_valid <= 1'b1;
      end else if (b_fire) begin
        b_valid <= 1'b0;
      end
    end
  end

  assign o_push = b_fire;
  assign o_pop  = pop && (o_count != 2'd0);
  assign empty  = (o_count == 2'd0);
  assign res    = out_q[o_rd];

  always_ff @(posedge clk) begin
    if (o_push) begin
      out_q[o_wr] <= '{data: b_value, last: b_last, status: b_status};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_wr    <= 1'b0;
      o_rd    <= 1'b0;
      o_count <= 2'd0;
    end else begin
      if (o_push) begin
        o_wr <= ~o_wr;
      end
      if (o_pop) begin
        o_rd <= ~o_rd;
      end
      case ({o_push, o_pop})
        2'b10:   o_count <= o_count + 2'd1;
        2'b01:   o_count <= o_count - 2'd1;
        default: o_count <= o_count;
      endcase
    end
  end

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (b_valid && b_status != lzd_pkg::ST_OK) |-> b_last)
    else $error("error item without last mark");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    a_valid |-> (a_idx < a_cmd.len))
    else $error("issue index past command length");

  a_oq_bound: assert property (@(posedge clk) disable iff (rst)
    (o_count == 2'd2) |=> (o_count != 2'd3))
    else $error("result queue overflow");

endmodule
`default_nettype wire

[verif/tb_lz77_stream_decompressor_core.sv]
module tb_lz77_stream_decompressor_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int SW          = lzd_pkg::SIZE_W;
  localparam int AW          = lzd_pkg::AW;
  localparam int WS          = lzd_pkg::WINDOW_SIZE;
  localparam lzd_pkg::res_t NIL = '0;

  typedef enum logic [2:0] {
    P_IDLE, P_SIZE0, P_SIZE1, P_SIZE2, P_FLAG, P_ITEM, P_TOK2
  } phase_e;

  typedef enum int {SH_GOOD, SH_CUT, SH_FAR, SH_BADTAG, SH_EMPTY} shape_e;

  typedef struct {
    logic [7:0]    b;
    logic          s;
    logic          typed;
    lzd_pkg::res_t want;
  } row_t;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic [7:0] in_byte;
  logic       start_req;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte;
  logic       last;
  logic [1:0] status;
  logic       cfg_we;
  logic [7:0] cfg_data;

  lz77_stream_decompressor_core dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_byte  (in_byte),
    .start_req(start_req),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .last     (last),
    .status   (status),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // decoder state mirrored in the bench
  logic [7:0]    win [WS];
  logic [SW-1:0] n_out;
  logic [SW-1:0] size_decl;
  phase_e        phase;
  logic [7:0]    flags;
  logic [2:0]    fidx;
  logic [7:0]    tok_hi;
  logic [7:0]    tag_model;

  lzd_pkg::res_t step_out[$];
  lzd_pkg::res_t expected_out[$];
  int   n_bad;
  bit   idle_on;
  bit   rx_hold;

  // directed items; typed rows carry the one result they must give
  row_t plan [28] = '{
    '{8'h55, 1'b0, 1'b0, NIL},                              // stray byte while idle
    '{8'h11, 1'b1, 1'b1, '{8'h00, 1'b1, lzd_pkg::ST_TAG}},  // wrong tag
    '{8'h10, 1'b1, 1'b0, NIL},                              // zero size header
    '{8'h00, 1'b0, 1'b0, NIL},
    '{8'h00, 1'b0, 1'b0, NIL},
    '{8'h00, 1'b0, 1'b0, NIL},
    '{8'h10, 1'b1, 1'b0, NIL},                              // size 3
    '{8'h03, 1'b0, 1'b0, NIL},
    '{8'h00, 1'b0, 1'b0, NIL},
    '{8'h00, 1'b0, 1'b0, NIL},
    '{8'h40, 1'b0, 1'b0, NIL},
    '{8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b0, lzd_pkg::ST_OK}},
    '{8'h00, 1'b0, 1'b0, NIL},                              // copy of 3 cut to 2
    '{8'h00, 1'b0, 1'b0, NIL},
    '{8'h10, 1'b1, 1'b0, NIL},                              // largest size
    '{8'hFF, 1'b0, 1'b0, NIL},
    '{8'hFF, 1'b0, 1'b0, NIL},
    '{8'hFF, 1'b0, 1'b0, NIL},
    '{8'h00, 1'b0, 1'b0, NIL},
    '{8'h00, 1'b0, 1'b1, '{8'h00, 1'b0, lzd_pkg::ST_OK}},
    '{8'h10, 1'b1, 1'b0, NIL},                              // restart mid-stream
    '{8'h02, 1'b0, 1'b0, NIL},
    '{8'h00, 1'b0, 1'b0, NIL},
    '{8'h00, 1'b0, 1'b0, NIL},
    '{8'h40, 1'b0, 1'b0, NIL},
    '{8'h80, 1'b0, 1'b1, '{8'h80, 1'b0, lzd_pkg::ST_OK}},
    '{8'h0F, 1'b0, 1'b0, NIL},                              // distance 4096, too far
    '{8'hFF, 1'b0, 1'b1, '{8'h00, 1'b1, lzd_pkg::ST_DIST}}
  };

  function automatic bit emit(input logic [7:0] v);
    win[n_out[AW-1:0]] = v;
    n_out = n_out + 24'd1;
    step_out.push_back('{v, (n_out == size_decl), lzd_pkg::ST_OK});
    return n_out == size_decl;
  endfunction

  function automatic void next_slot();
    if (fidx == 3'd7) begin
      fidx  = '0;
      phase = P_FLAG;
    end else begin
      fidx  = fidx + 3'd1;
      phase = P_ITEM;
    end
  endfunction

  function automatic void decode_item(input logic [7:0] b, input logic s);
    logic [4:0]    count;
    logic [12:0]   distance;
    logic [SW-1:0] ix;
    bit            done;
    if (s) begin
      n_out     = '0;
      size_decl = '0;
      flags     = '0;
      fidx      = '0;
      tok_hi    = '0;
      if (b != tag_model) begin
        phase = P_IDLE;
        step_out.push_back('{8'h00, 1'b1, lzd_pkg::ST_TAG});
      end else begin
        phase = P_SIZE0;
      end
      return;
    end
    case (phase)
      P_SIZE0: begin
        size_decl = {16'h0, b};
        phase     = P_SIZE1;
      end
      P_SIZE1: begin
        size_decl[15:8] = b;
        phase           = P_SIZE2;
      end
      P_SIZE2: begin
        size_decl[23:16] = b;
        phase = (size_decl == '0) ? P_IDLE : P_FLAG;
      end
      P_FLAG: begin
        flags = b;
        fidx  = '0;
        phase = P_ITEM;
      end
      P_ITEM: begin
        if (flags[3'd7 - fidx]) begin
          tok_hi = b;
          phase  = P_TOK2;
        end else if (emit(b)) begin
          phase = P_IDLE;
        end else begin
          next_slot();
        end
      end
      P_TOK2: begin
        count    = {1'b0, tok_hi[7:4]} + 5'd3;
        distance = {1'b0, tok_hi[3:0], b} + 13'd1;
        if (SW'(distance) > n_out) begin
          step_out.push_back('{8'h00, 1'b1, lzd_pkg::ST_DIST});
          phase = P_IDLE;
        end else begin
          done = 1'b0;
          while (count != '0 && !done) begin
            ix    = n_out - SW'(distance);
            count = count - 5'd1;
            done  = emit(win[ix[AW-1:0]]);
          end
          if (done) begin
            phase = P_IDLE;
          end else begin
            next_slot();
          end
        end
      end
      default: phase = P_IDLE;
    endcase
  endfunction

  task automatic send(input logic [7:0] b, input logic s,
                      input logic typed = 1'b0, input lzd_pkg::res_t want = '0);
    while (idle_on && $urandom_range(99) < 21) begin
      push = 1'b0;
      @(negedge clk);
    end
    push      = 1'b1;
    in_byte   = b;
    start_req = s;
    @(posedge clk);
    while (full) @(posedge clk);
    step_out.delete();
    decode_item(b, s);
    if (typed) begin
      expected_out.push_back(want);
    end else begin
      foreach (step_out[k]) expected_out.push_back(step_out[k]);
    end
    @(negedge clk);
  endtask

  task automatic settle();
    push = 1'b0;
    while (expected_out.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_tag(input logic [7:0] v);
    cfg_data = v;
    cfg_we   = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
    tag_model = v;
  endtask

  // one stream: header, then flag bytes with literals and back references; a bad-tag stream is the tag byte alone
  task automatic random_stream(input shape_e shape, input int size, input int cap,
                               input bit longrun, output int sent);
    logic [7:0]  f;
    logic [11:0] d;
    logic [3:0]  len;
    logic [23:0] sz;
    int          made;
    int          lim;
    sent = 0;
    made = 0;
    sz   = 24'(size);
    if (shape == SH_BADTAG) begin
      send(tag_model ^ 8'($urandom_range(255, 1)), 1'b1);
      sent = 1;
      return;
    end
    send(tag_model, 1'b1);
    send(sz[7:0], 1'b0);
    send(sz[15:8], 1'b0);
    send(sz[23:16], 1'b0);
    sent = 4;
    while (made < size && sent < cap + 4) begin
      f = longrun ? 8'hFF : 8'($urandom);
      if (made == 0) begin
        f[7] = 1'b0;          // nothing to copy from yet
        if (shape == SH_FAR) f[6] = 1'b1;
      end
      send(f, 1'b0);
      sent++;
      for (int i = 7; i >= 0; i--) begin
        if (made >= size || sent >= cap + 4) break;
        if (!f[i]) begin
          send(8'($urandom), 1'b0);
          made++;
          sent++;
        end else begin
          len = longrun ? 4'($urandom_range(15, 12)) : 4'($urandom_range(15));
          lim = (made < WS) ? made : WS;
          if (shape == SH_FAR) d = 12'($urandom_range(WS - 1, made));
          else d = 12'($urandom_range(lim - 1, 0));
          send({len, d[11:8]}, 1'b0);
          send(d[7:0], 1'b0);
          sent += 2;
          if (shape == SH_FAR) return;
          made += int'(len) + 3;
        end
      end
    end
  endtask

  task automatic random_phase(input int budget);
    int done_items;
    int n;
    int pick;
    int sz;
    done_items = 0;
    while (done_items < budget) begin
      pick = $urandom_range(99);
      n    = 0;
      if (pick < 60) begin
        sz = ($urandom_range(9) == 0) ? $urandom_range(300, 49) : $urandom_range(48, 1);
        random_stream(SH_GOOD, sz, budget - done_items, 1'b0, n);
      end else if (pick < 72) begin
        // abandoned part way, the next tag byte restarts it
        random_stream(SH_CUT, $urandom_range(24'hFFFFFF, 200), $urandom_range(12, 2),
                      1'b0, n);
      end else if (pick < 82) begin
        random_stream(SH_FAR, $urandom_range(48, 2), budget - done_items, 1'b0, n);
      end else if (pick < 89) begin
        random_stream(SH_BADTAG, 0, 0, 1'b0, n);
      end else if (pick < 94) begin
        random_stream(SH_EMPTY, 0, 0, 1'b0, n);
      end else if (phase == P_IDLE) begin
        n = $urandom_range(3, 1);
        repeat (n) send(8'($urandom), 1'b0);
      end
      done_items += n;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        pop = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold = 1'b0;
      end
      pop = !idle_on || ($urandom_range(99) >= 21);
    end
  end

  always @(posedge clk) begin
    lzd_pkg::res_t want;
    if (!rst && pop && !empty) begin
      if (expected_out.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("%0t: unexpected result byte %h last %0b status %0d",
                   $time, out_byte, last, status);
      end else begin
        want = expected_out.pop_front();
        if (out_byte !== want.data || last !== want.last || status !== want.status) begin
          n_bad++;
          if (n_bad <= 10)
            $display("%0t: expected byte %h last %0b status %0d, got %h %0b %0d",
                     $time, want.data, want.last, want.status, out_byte, last, status);
        end
      end
    end
  end

  // ends the run if nothing moves on either side for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int n;
    rst       = 1'b1;
    push      = 1'b0;
    in_byte   = '0;
    start_req = 1'b0;
    cfg_we    = 1'b0;
    cfg_data  = '0;
    idle_on   = 1'b1;
    rx_hold   = 1'b0;
    n_bad     = 0;
    n_out     = '0;
    size_decl = '0;
    phase     = P_IDLE;
    flags     = '0;
    fidx      = '0;
    tok_hi    = '0;
    tag_model = lzd_pkg::TAG_RESET;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) send(plan[i].b, plan[i].s, plan[i].typed, plan[i].want);
    settle();

    idle_on = 1'b0;
    set_tag(8'h00);
    random_phase(46);
    settle();

    idle_on = 1'b1;
    set_tag(8'hFF);
    random_phase(46);
    settle();

    set_tag(8'($urandom_range(254, 1)));
    random_phase(46);
    // copy-heavy stream; receiver stalls meanwhile
    rx_hold = 1'b1;
    random_stream(SH_GOOD, 4600, 40, 1'b1, n);
    settle();

    if (n_bad == 0 && expected_out.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
hdl/lzd_pkg.sv
hdl/lzd_front.sv
hdl/lzd_cmd_fifo.sv
hdl/lzd_back.sv
hdl/lz77_stream_decompressor_core.sv
verif/tb_lz77_stream_decompressor_core.sv
